[src/vneg_pkg.sv]
// Shared types, constants and the square-root weight table of the voxel edge generator.
package vneg_pkg;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS = 2'd3;

    // Request kinds carried on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRC,
        ST_SCAN
    } t_state;

    // S(v) = round(65536 * sqrt(v) / 63), v = 0..255, max 16612
    typedef logic [255:0][14:0] t_root_tab;

    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] trial;
        for (int v = 0; v < 256; v++) begin
            n   = 64'(v) << 34;
            res = 64'd0;
            for (int i = 20; i >= 0; i--) begin
                trial = res | (64'd1 << i);
                if (trial * trial <= n) begin
                    res = trial;
                end
            end
            tab[v] = 15'((res + 64'd63) / 64'd126);
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

endpackage

[src/vneg_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module vneg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_re,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic             i_re;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/voxel_neighbor_edge_generator_core.sv]
// Voxel neighborhood edge generator: voxel store, neighbor scan and edge output.
//
// Usage: requests arrive on the s_axis channel. tuser = 0 stores tdata's intensity at
// (pos_x, pos_y, pos_z) and gives no result; tuser = 1 queries the source voxel at that
// position. A query emits one edge on m_axis for every neighbor in the 3x3x3 cube
// (radius 1) clipped to configured/array size, source skipped, x outer / z inner, with
// tlast on the final edge. Out-of-size queries, radius 0 and lone voxels give nothing.
// Config writes (i_cfg_we/idx/data) are taken any cycle; issue them while idle.
// Sequence: a write is complete once accepted. A query is accepted with its source
// voxel read issued, ST_SRC registers the source weight, then ST_SCAN steps through
// each cube point (up to 27, the source point is a bubble); each neighbor edge moves
// through the read stage, its voxel in the RAM read register, into the output
// register. The single voxel RAM read port, one read per neighbor, paces the scan.
// The next request is taken once the last edge has left the read stage, even while
// that edge still sits in the output register.
// Reset: control state is cleared, sizes return to 16 and radius to 1; voxel contents
// are undefined until written. A stalled receiver freezes the scan, the RAM read
// register and the output register; nothing is dropped.
module voxel_neighbor_edge_generator_core #(
    parameter int DIM_X = 16,
    parameter int DIM_Y = 16,
    parameter int DIM_Z = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: pos_x[3:0], pos_y[7:4], pos_z[11:8], intensity[19:12], zero fill
    input  logic [vneg_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: func[0]
    input  logic                              i_s_axis_tuser,
    // edge channel
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: src_x[3:0], src_y[7:4], src_z[11:8], dst_x[15:12], dst_y[19:16],
    //        dst_z[23:20], dist_sq[25:24], weight[41:26], zero fill
    output logic [vneg_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tlast: last edge of the query
    output logic                              o_m_axis_tlast,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [4:0]                        i_cfg_data
);
    import vneg_pkg::*;

    localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Linear voxel address, x major, z minor
    function automatic logic [AW-1:0] f_addr(input logic [4:0] x, input logic [4:0] y,
                                             input logic [4:0] z);
        logic [31:0] t;
        t = (32'(x) * 32'(DIM_Y) + 32'(y)) * 32'(DIM_Z) + 32'(z);
        return t[AW-1:0];
    endfunction

    // Configuration
    logic [4:0] r_size_x, r_size_y, r_size_z;
    logic       r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 5'd16;
            r_size_y <= 5'd16;
            r_size_z <= 5'd16;
            r_radius <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_RADIUS: r_radius <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request fields
    logic       in_func;
    logic [3:0] in_px, in_py, in_pz;
    logic [7:0] in_val;
    logic [4:0] px5, py5, pz5;

    assign in_func = i_s_axis_tuser;
    assign in_px   = i_s_axis_tdata[3:0];
    assign in_py   = i_s_axis_tdata[7:4];
    assign in_pz   = i_s_axis_tdata[11:8];
    assign in_val  = i_s_axis_tdata[19:12];
    assign px5     = {1'b0, in_px};
    assign py5     = {1'b0, in_py};
    assign pz5     = {1'b0, in_pz};

    // Scan bounds of the request position
    logic [4:0] px1, py1, pz1;
    logic [4:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic [4:0] lp_x, lp_y, lp_z;
    logic       in_dim, in_size, lone, final_is_src;

    assign px1 = px5 + 5'd1;
    assign py1 = py5 + 5'd1;
    assign pz1 = pz5 + 5'd1;

    assign in_dim  = (32'(in_px) < DIM_X) && (32'(in_py) < DIM_Y) && (32'(in_pz) < DIM_Z);
    assign in_size = in_dim && (px5 < r_size_x) && (py5 < r_size_y) && (pz5 < r_size_z);

    assign lo_x = (in_px == 4'd0) ? 5'd0 : px5 - 5'd1;
    assign lo_y = (in_py == 4'd0) ? 5'd0 : py5 - 5'd1;
    assign lo_z = (in_pz == 4'd0) ? 5'd0 : pz5 - 5'd1;
    // the upper edge stops at the smaller of the configured size and the array size
    assign hi_x = ((px1 < r_size_x) && (32'(px1) < DIM_X)) ? px1 : px5;
    assign hi_y = ((py1 < r_size_y) && (32'(py1) < DIM_Y)) ? py1 : py5;
    assign hi_z = ((pz1 < r_size_z) && (32'(pz1) < DIM_Z)) ? pz1 : pz5;

    assign lone         = (lo_x == hi_x) && (lo_y == hi_y) && (lo_z == hi_z);
    assign final_is_src = (hi_x == px5) && (hi_y == py5) && (hi_z == pz5);

    // Last emitted point: the scan's final corner, or the point before it when that
    // corner is the source itself
    always_comb begin
        lp_x = hi_x;
        lp_y = hi_y;
        lp_z = hi_z;
        if (final_is_src) begin
            if (hi_z != lo_z) begin
                lp_z = hi_z - 5'd1;
            end else if (hi_y != lo_y) begin
                lp_y = hi_y - 5'd1;
            end else begin
                lp_x = hi_x - 5'd1;
            end
        end
    end

    // Query state
    t_state     r_state, n_state;
    logic [3:0] r_src_x, r_src_y, r_src_z;
    logic [4:0] r_lo_x, r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z;
    logic [4:0] r_lp_x, r_lp_y, r_lp_z;
    logic [4:0] r_cur_x, r_cur_y, r_cur_z;
    logic [4:0] n_cur_x, n_cur_y, n_cur_z;
    logic [14:0] r_ssrc;

    // Read stage: one edge whose voxel sits in the RAM read register
    logic       r_v2;
    logic [4:0] r_d2_x, r_d2_y, r_d2_z;
    logic [1:0] r_d2_sq;
    logic       r_d2_last;

    // Output register
    logic        r_o_valid;
    logic [3:0]  r_o_src_x, r_o_src_y, r_o_src_z, r_o_dst_x, r_o_dst_y, r_o_dst_z;
    logic [1:0]  r_o_sq;
    logic [15:0] r_o_weight;
    logic        r_o_last;

    // Control
    logic       adv, in_ready, in_acc, acc_query, ram_we, ram_re, issue, cur_is_src;
    logic       cur_at_end;
    logic [4:0] a_x, a_y, a_z;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_q;

    assign adv        = !r_o_valid || i_m_axis_tready;
    assign in_ready   = (r_state == ST_IDLE) && !r_v2;
    assign in_acc     = in_ready && i_s_axis_tvalid;
    assign acc_query  = in_acc && (in_func == FUNC_QUERY) && in_size && r_radius && !lone;
    assign cur_is_src = (r_cur_x == {1'b0, r_src_x}) && (r_cur_y == {1'b0, r_src_y}) &&
                        (r_cur_z == {1'b0, r_src_z});
    assign cur_at_end = (r_cur_x == r_hi_x) && (r_cur_y == r_hi_y) && (r_cur_z == r_hi_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        issue   = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        a_x     = px5;
        a_y     = py5;
        a_z     = pz5;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_cur_z = r_cur_z;
        unique case (r_state)
            ST_IDLE: begin
                ram_we = in_acc && (in_func == FUNC_WRITE) && in_dim;
                ram_re = acc_query;
                if (acc_query) begin
                    n_state = ST_SRC;
                end
            end
            ST_SRC: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                a_x = r_cur_x;
                a_y = r_cur_y;
                a_z = r_cur_z;
                if (adv) begin
                    issue  = 1'b1;
                    ram_re = !cur_is_src;
                    if (r_cur_z != r_hi_z) begin
                        n_cur_z = r_cur_z + 5'd1;
                    end else begin
                        n_cur_z = r_lo_z;
                        if (r_cur_y != r_hi_y) begin
                            n_cur_y = r_cur_y + 5'd1;
                        end else begin
                            n_cur_y = r_lo_y;
                            n_cur_x = r_cur_x + 5'd1;
                        end
                    end
                    if (cur_at_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign ram_addr = f_addr(a_x, a_y, a_z);

    vneg_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (in_val),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    // Query registers
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_src_x <= in_px;
            r_src_y <= in_py;
            r_src_z <= in_pz;
            r_lo_x  <= lo_x;
            r_lo_y  <= lo_y;
            r_lo_z  <= lo_z;
            r_hi_x  <= hi_x;
            r_hi_y  <= hi_y;
            r_hi_z  <= hi_z;
            r_lp_x  <= lp_x;
            r_lp_y  <= lp_y;
            r_lp_z  <= lp_z;
            r_cur_x <= lo_x;
            r_cur_y <= lo_y;
            r_cur_z <= lo_z;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_cur_z <= n_cur_z;
        end
        if (r_state == ST_SRC) begin
            r_ssrc <= ROOT_TAB[ram_q];
        end
    end

    // Read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_v2      <= issue && !cur_is_src;
            r_o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2_x    <= r_cur_x;
            r_d2_y    <= r_cur_y;
            r_d2_z    <= r_cur_z;
            r_d2_sq   <= 2'(r_cur_x != {1'b0, r_src_x}) + 2'(r_cur_y != {1'b0, r_src_y}) +
                         2'(r_cur_z != {1'b0, r_src_z});
            r_d2_last <= (r_cur_x == r_lp_x) && (r_cur_y == r_lp_y) && (r_cur_z == r_lp_z);
            if (r_v2) begin
                r_o_src_x  <= r_src_x;
                r_o_src_y  <= r_src_y;
                r_o_src_z  <= r_src_z;
                r_o_dst_x  <= r_d2_x[3:0];
                r_o_dst_y  <= r_d2_y[3:0];
                r_o_dst_z  <= r_d2_z[3:0];
                r_o_sq     <= r_d2_sq;
                r_o_weight <= {1'b0, r_ssrc} - {1'b0, ROOT_TAB[ram_q]};
                r_o_last   <= r_d2_last;
            end
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'd0, r_o_weight, r_o_sq, r_o_dst_z, r_o_dst_y, r_o_dst_x,
                              r_o_src_z, r_o_src_y, r_o_src_x};
    assign o_m_axis_tlast  = r_o_last;

endmodule

[src/vneg_checker.sv]
// Port-level assertions for the voxel edge generator, bound to the top level.
module vneg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // stalled edge holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("edge changed while stalled");

    // neighbor never equals the source
    a_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[11:0] != o_m_axis_tdata[23:12])
        else $error("edge points at its own source");

    // distance counts the differing axes
    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[25:24] ==
            2'(o_m_axis_tdata[3:0] != o_m_axis_tdata[15:12]) +
            2'(o_m_axis_tdata[7:4] != o_m_axis_tdata[19:16]) +
            2'(o_m_axis_tdata[11:8] != o_m_axis_tdata[23:20]))
        else $error("squared distance does not match coordinates");

    // weight stays in the table's range
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[41:26]) <= 16'sd16612) &&
                            ($signed(o_m_axis_tdata[41:26]) >= -16'sd16612))
        else $error("weight out of range");

endmodule

bind voxel_neighbor_edge_generator_core vneg_checker u_vneg_checker (.*);
